>>> rtl/rps_pkg.sv
package rps_pkg;

  // Sizes of the partitioner.
  localparam int MAX_RADIX_BITS = 6;
  localparam int COUNT_BITS     = 32;
  localparam int NUM_BUCKETS    = 1 << MAX_RADIX_BITS;
  localparam int POS_W          = 33;
  localparam int KEY_W          = 64;
  localparam int VALUE_W        = 64;
  localparam int RADIX_W        = 3;
  localparam int PAD_W          = 16;
  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DATA_W     = 16;

  typedef logic [MAX_RADIX_BITS-1:0] bucket_t;
  typedef logic [COUNT_BITS-1:0]     count_t;
  typedef logic [POS_W-1:0]          pos_t;

  // Request codes of an input item.
  typedef enum logic [1:0] {
    REQ_COUNT    = 2'd0,
    REQ_FINALIZE = 2'd1,
    REQ_SCATTER  = 2'd2,
    REQ_NONE     = 2'd3
  } req_e;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RADIX_BITS     = 1'b0,
    CFG_PADDING_LENGTH = 1'b1
  } cfg_reg_e;

  // Control states of the top level.
  typedef enum logic {
    ST_IDLE,
    ST_FINALIZE
  } state_e;

  // Command to the count store: a write of one count or a clear of one bucket.
  typedef struct packed {
    logic    wr;
    logic    clr;
    bucket_t addr;
    count_t  data;
  } cnt_cmd_t;

  // Control of the offset generator.
  typedef struct packed {
    logic load;
    logic step;
  } ofs_ctl_t;

  // Mask of the active partition bits; a radix above the maximum acts as the maximum.
  function automatic bucket_t bucket_mask(input logic [RADIX_W-1:0] radix);
    bucket_t m;
    begin
      m = '0;
      for (int b = 0; b < MAX_RADIX_BITS; b++) begin
        m[b] = (b < int'(radix));
      end
      return m;
    end
  endfunction

endpackage

>>> rtl/rps_ram.sv
module rps_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/rps_count_store.sv
module rps_count_store (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rps_pkg::bucket_t  rd_addr_i,
  input  rps_pkg::cnt_cmd_t cmd_i,
  output rps_pkg::count_t   count_o
);
  import rps_pkg::*;

  logic [NUM_BUCKETS-1:0] vld_q, vld_d;
  bucket_t raddr_q;
  logic    fwd_vld_q;
  bucket_t fwd_addr_q;
  count_t  fwd_data_q;
  count_t  ram_rdata;

  rps_ram #(
    .Width(COUNT_BITS),
    .Depth(NUM_BUCKETS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.wr),
    .waddr_i(cmd_i.addr),
    .wdata_i(cmd_i.data),
    .raddr_i(rd_addr_i),
    .rdata_o(ram_rdata)
  );

  // A bucket that was never written since reset or its last clear reads as zero.
  always_comb begin
    vld_d = vld_q;
    if (cmd_i.wr) begin
      vld_d[cmd_i.addr] = 1'b1;
    end
    if (cmd_i.clr) begin
      vld_d[cmd_i.addr] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      fwd_vld_q <= 1'b0;
    end else begin
      vld_q     <= vld_d;
      fwd_vld_q <= cmd_i.wr;
    end
  end

  // Read address and the latest write, kept to bypass a read that raced a write.
  always_ff @(posedge clk_i) begin
    raddr_q <= rd_addr_i;
    if (cmd_i.wr) begin
      fwd_addr_q <= cmd_i.addr;
      fwd_data_q <= cmd_i.data;
    end
  end

  always_comb begin
    if (!vld_q[raddr_q]) begin
      count_o = '0;
    end else if (fwd_vld_q && (fwd_addr_q == raddr_q)) begin
      count_o = fwd_data_q;
    end else begin
      count_o = ram_rdata;
    end
  end

  a_no_wr_and_clr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.wr && cmd_i.clr))
    else $error("count store got a write and a clear together");

endmodule

>>> rtl/rps_offset_gen.sv
module rps_offset_gen (
  input  logic                     clk_i,
  input  rps_pkg::ofs_ctl_t        ctl_i,
  input  logic [rps_pkg::PAD_W-1:0] pad_i,
  input  rps_pkg::count_t          count_i,
  output rps_pkg::pos_t            offset_o
);
  import rps_pkg::*;

  // Running prefix sum of counts and running (bucket+1) times padding.
  pos_t sum_q;
  pos_t pad_acc_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      sum_q     <= '0;
      pad_acc_q <= POS_W'(pad_i);
    end else if (ctl_i.step) begin
      sum_q     <= sum_q + POS_W'(count_i);
      pad_acc_q <= pad_acc_q + POS_W'(pad_i);
    end
  end

  assign offset_o = sum_q + pad_acc_q;

endmodule

>>> rtl/radix_partition_scatter_unit.sv
// Count and scatter: one item per cycle unless busy; each scatter item strobes one tuple record.
// Count items read, bump and write back a bucket count through a registered read port with bypass.
// Finalize: busy while walking 2^r buckets, r being the radix width capped at six, one per cycle;
// its offset records follow through the result registers, one per cycle, in bucket order.
// Reset clears all counts at once through per-bucket valid bits; write pointers start undefined.
// Results are strobed on valid_o for one cycle and cannot be stalled.
module radix_partition_scatter_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     req_type_i,
  input  logic [rps_pkg::KEY_W-1:0]      key_i,
  input  logic [rps_pkg::VALUE_W-1:0]    value_i,
  input  logic                           cfg_we_i,
  input  logic [rps_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rps_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output logic                           valid_o,
  output logic                           record_kind_o,
  output logic [5:0]                     partition_o,
  output logic [rps_pkg::POS_W-1:0]      position_o,
  output logic [rps_pkg::KEY_W-1:0]      out_key_o,
  output logic [rps_pkg::VALUE_W-1:0]    out_value_o,
  output logic                           last_o
);
  import rps_pkg::*;

  state_e state_q, state_d;

  logic [RADIX_W-1:0] radix_q;
  logic [PAD_W-1:0]   pad_q;

  logic    accept;
  bucket_t in_mask;
  bucket_t in_bkt;
  bucket_t widx_q, widx_d;
  logic    walk_last;

  // Item in the read-modify-write stage.
  logic         s1_vld_q, s1_vld_d;
  logic         s1_scat_q;
  bucket_t      s1_bkt_q;
  logic [KEY_W-1:0]   s1_key_q;
  logic [VALUE_W-1:0] s1_val_q;

  // Count store and offset generator.
  bucket_t  cnt_raddr;
  cnt_cmd_t cnt_cmd;
  count_t   cnt_eff;
  ofs_ctl_t ofs_ctl;
  pos_t     offset;

  // Write pointer memory with bypass of the latest write.
  logic    ptr_we;
  bucket_t ptr_waddr;
  pos_t    ptr_wdata;
  pos_t    ptr_rdata;
  pos_t    ptr_eff;
  logic    pfwd_vld_q;
  bucket_t pfwd_addr_q;
  pos_t    pfwd_data_q;

  // Result registers.
  logic         res_vld_q, res_vld_d;
  logic         res_kind_q, res_kind_d;
  bucket_t      res_part_q, res_part_d;
  pos_t         res_pos_q, res_pos_d;
  logic [KEY_W-1:0]   res_key_q, res_key_d;
  logic [VALUE_W-1:0] res_val_q, res_val_d;
  logic         res_last_q, res_last_d;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= RADIX_W'(MAX_RADIX_BITS);
      pad_q   <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_RADIX_BITS) begin
        radix_q <= cfg_wdata_i[RADIX_W-1:0];
      end
      if (cfg_idx_i == CFG_PADDING_LENGTH) begin
        pad_q <= cfg_wdata_i[PAD_W-1:0];
      end
    end
  end

  // Partition selection.
  assign in_mask   = bucket_mask(radix_q);
  assign in_bkt    = key_i[MAX_RADIX_BITS-1:0] & in_mask;
  assign accept    = start && !busy;
  assign walk_last = (widx_q == in_mask);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (req_type_i == REQ_FINALIZE)) begin
          state_d = ST_FINALIZE;
        end
      end
      ST_FINALIZE: begin
        if (walk_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State outputs: handshake, walk index, memory commands.
  always_comb begin
    busy        = (state_q == ST_FINALIZE);
    widx_d      = widx_q;
    cnt_raddr   = in_bkt;
    cnt_cmd     = '0;
    ofs_ctl     = '0;
    ptr_we      = 1'b0;
    ptr_waddr   = s1_bkt_q;
    ptr_wdata   = ptr_eff + POS_W'(1);
    unique case (state_q)
      ST_IDLE: begin
        widx_d = '0;
        if (req_type_i == REQ_FINALIZE) begin
          cnt_raddr = '0;
        end
        ofs_ctl.load = accept && (req_type_i == REQ_FINALIZE);
        if (s1_vld_q && !s1_scat_q) begin
          cnt_cmd.wr   = 1'b1;
          cnt_cmd.addr = s1_bkt_q;
          cnt_cmd.data = (&cnt_eff) ? cnt_eff : cnt_eff + COUNT_BITS'(1);
        end
        ptr_we = s1_vld_q && s1_scat_q;
      end
      ST_FINALIZE: begin
        widx_d       = widx_q + MAX_RADIX_BITS'(1);
        cnt_raddr    = widx_q + MAX_RADIX_BITS'(1);
        cnt_cmd.clr  = 1'b1;
        cnt_cmd.addr = widx_q;
        ofs_ctl.step = 1'b1;
        ptr_we       = 1'b1;
        ptr_waddr    = widx_q;
        ptr_wdata    = offset;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      s1_vld_q   <= 1'b0;
      pfwd_vld_q <= 1'b0;
      res_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      s1_vld_q   <= s1_vld_d;
      pfwd_vld_q <= ptr_we;
      res_vld_q  <= res_vld_d;
    end
  end

  // Capture of a count or scatter item for its read-modify-write cycle.
  assign s1_vld_d = accept && ((req_type_i == REQ_COUNT) || (req_type_i == REQ_SCATTER));

  always_ff @(posedge clk_i) begin
    widx_q    <= widx_d;
    s1_scat_q <= (req_type_i == REQ_SCATTER);
    s1_bkt_q  <= in_bkt;
    s1_key_q  <= key_i;
    s1_val_q  <= value_i;
    if (ptr_we) begin
      pfwd_addr_q <= ptr_waddr;
      pfwd_data_q <= ptr_wdata;
    end
  end

  rps_count_store u_count_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_addr_i(cnt_raddr),
    .cmd_i    (cnt_cmd),
    .count_o  (cnt_eff)
  );

  rps_offset_gen u_offset_gen (
    .clk_i   (clk_i),
    .ctl_i   (ofs_ctl),
    .pad_i   (pad_q),
    .count_i (cnt_eff),
    .offset_o(offset)
  );

  rps_ram #(
    .Width(POS_W),
    .Depth(NUM_BUCKETS)
  ) u_ptr_ram (
    .clk_i  (clk_i),
    .we_i   (ptr_we),
    .waddr_i(ptr_waddr),
    .wdata_i(ptr_wdata),
    .raddr_i(in_bkt),
    .rdata_o(ptr_rdata)
  );

  // A pointer written at the edge of the read comes from the bypass register.
  assign ptr_eff = (pfwd_vld_q && (pfwd_addr_q == s1_bkt_q)) ? pfwd_data_q : ptr_rdata;

  // Result selection: offset records during the walk, tuple records for scatter items otherwise.
  always_comb begin
    res_vld_d  = 1'b0;
    res_kind_d = 1'b0;
    res_part_d = widx_q;
    res_pos_d  = offset;
    res_key_d  = '0;
    res_val_d  = '0;
    res_last_d = walk_last;
    if (state_q == ST_FINALIZE) begin
      res_vld_d = 1'b1;
    end else if (s1_vld_q && s1_scat_q) begin
      res_vld_d  = 1'b1;
      res_kind_d = 1'b1;
      res_part_d = s1_bkt_q;
      res_pos_d  = ptr_eff;
      res_key_d  = s1_key_q;
      res_val_d  = s1_val_q;
      res_last_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    res_kind_q <= res_kind_d;
    res_part_q <= res_part_d;
    res_pos_q  <= res_pos_d;
    res_key_q  <= res_key_d;
    res_val_q  <= res_val_d;
    res_last_q <= res_last_d;
  end

  assign valid_o       = res_vld_q;
  assign record_kind_o = res_kind_q;
  assign partition_o   = 6'(res_part_q);
  assign position_o    = res_pos_q;
  assign out_key_o     = res_key_q;
  assign out_value_o   = res_val_q;
  assign last_o        = res_last_q;

  a_walk_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINALIZE) |-> !s1_vld_q)
    else $error("item in read-modify-write stage during the finalize walk");

  a_scatter_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (req_type_i == REQ_SCATTER)) |-> ##2 (valid_o && record_kind_o && last_o))
    else $error("scatter item produced no tuple record");

  a_walk_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_FINALIZE) && walk_last) |=> (valid_o && last_o && !record_kind_o && !busy))
    else $error("finalize walk did not end with a last offset record");

endmodule

>>> dv/tb_radix_partition_scatter_unit.sv
`timescale 1ns / 1ps

module tb_radix_partition_scatter_unit;
  import rps_pkg::*;

  // Cycles for a count or scatter item to settle inside the block.
  localparam int SETTLE_CYCLES = 4;
  localparam int RANDOM_ITEMS  = 220;

  // One record on the result ports.
  typedef struct packed {
    logic                kind;
    logic [5:0]          part;
    pos_t                pos;
    logic [KEY_W-1:0]    key;
    logic [VALUE_W-1:0]  val;
    logic                last;
  } partition_record_t;

  // Work for the driver: an item, a register write, or a pause until drained.
  typedef enum logic [1:0] {
    ENT_ITEM,
    ENT_CFG,
    ENT_DRAIN
  } entry_kind_e;

  typedef struct {
    entry_kind_e           kind;
    req_e                  req;
    logic [KEY_W-1:0]      key;
    logic [VALUE_W-1:0]    val;
    cfg_reg_e              idx;
    logic [CFG_DATA_W-1:0] data;
  } backlog_entry_t;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  start       = 1'b0;
  logic                  busy;
  logic [1:0]            req_type_i  = '0;
  logic [KEY_W-1:0]      key_i       = '0;
  logic [VALUE_W-1:0]    value_i     = '0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  valid_o;
  logic                  record_kind_o;
  logic [5:0]            partition_o;
  pos_t                  position_o;
  logic [KEY_W-1:0]      out_key_o;
  logic [VALUE_W-1:0]    out_value_o;
  logic                  last_o;

  backlog_entry_t    item_backlog[$];
  partition_record_t expected_records[$];

  // Shadow copy of the partitioner state and registers.
  count_t                shadow_counts[NUM_BUCKETS];
  pos_t                  shadow_ptrs[NUM_BUCKETS];
  logic [RADIX_W-1:0]    shadow_radix;
  logic [PAD_W-1:0]      shadow_pad;

  int quiet_cycles = 0;
  int gap_left     = 0;
  int burst_left   = 8;
  int mismatches   = 0;

  radix_partition_scatter_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .req_type_i    (req_type_i),
    .key_i         (key_i),
    .value_i       (value_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .valid_o       (valid_o),
    .record_kind_o (record_kind_o),
    .partition_o   (partition_o),
    .position_o    (position_o),
    .out_key_o     (out_key_o),
    .out_value_o   (out_value_o),
    .last_o        (last_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Work out the records that one accepted item causes and update the shadow state.
  task automatic partition_predict(input logic [1:0] req, input logic [KEY_W-1:0] key,
                                   input logic [VALUE_W-1:0] val);
    int                bits;
    int                fanout;
    bucket_t           b;
    pos_t              sum;
    pos_t              off;
    partition_record_t rec;
    bits = (int'(shadow_radix) > MAX_RADIX_BITS) ? MAX_RADIX_BITS : int'(shadow_radix);
    fanout = 1 << bits;
    b = key[MAX_RADIX_BITS-1:0] & bucket_t'(fanout - 1);
    case (req_e'(req))
      REQ_COUNT: begin
        if (shadow_counts[b] != '1) shadow_counts[b] = shadow_counts[b] + 1'b1;
      end
      REQ_FINALIZE: begin
        sum = '0;
        for (int i = 0; i < fanout; i++) begin
          off = sum + pos_t'(i + 1) * pos_t'(shadow_pad);
          sum = sum + pos_t'(shadow_counts[i]);
          shadow_ptrs[i] = off;
          shadow_counts[i] = '0;
          rec.kind = 1'b0;
          rec.part = 6'(i);
          rec.pos  = off;
          rec.key  = '0;
          rec.val  = '0;
          rec.last = (i == fanout - 1);
          expected_records.push_back(rec);
        end
      end
      REQ_SCATTER: begin
        rec.kind = 1'b1;
        rec.part = 6'(b);
        rec.pos  = shadow_ptrs[b];
        rec.key  = key;
        rec.val  = val;
        rec.last = 1'b1;
        expected_records.push_back(rec);
        shadow_ptrs[b] = shadow_ptrs[b] + 1'b1;
      end
      default: begin
        // The unused request code leaves everything as it is.
      end
    endcase
  endtask

  function automatic string record_text(input partition_record_t r);
    return $sformatf("kind %0d part %0d pos %h key %h value %h last %0d",
                     r.kind, r.part, r.pos, r.key, r.val, r.last);
  endfunction

  // Driver: presents items in bursts, writes registers only while the block is idle.
  always @(posedge clk_i) begin : drive_proc
    logic           nxt_start;
    logic           nxt_we;
    logic           idle;
    backlog_entry_t head;
    if (rst_ni) begin
      nxt_start = start;
      nxt_we = 1'b0;
      idle = (expected_records.size() == 0) && (quiet_cycles >= SETTLE_CYCLES) &&
             !start && !busy && !cfg_we_i;
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          CFG_RADIX_BITS:     shadow_radix = cfg_wdata_i[RADIX_W-1:0];
          CFG_PADDING_LENGTH: shadow_pad = cfg_wdata_i[PAD_W-1:0];
          default: ;
        endcase
      end
      if (start && !busy) partition_predict(req_type_i, key_i, value_i);
      if (valid_o || (start && !busy)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles < 1000) begin
        quiet_cycles <= quiet_cycles + 1;
      end
      // A held item stays on the ports until the block takes it.
      if (!(start && busy)) begin
        nxt_start = 1'b0;
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
        end else if (item_backlog.size() > 0) begin
          head = item_backlog[0];
          case (head.kind)
            ENT_ITEM: begin
              req_type_i <= head.req;
              key_i <= head.key;
              value_i <= head.val;
              nxt_start = 1'b1;
              void'(item_backlog.pop_front());
              if (burst_left > 1) begin
                burst_left <= burst_left - 1;
              end else begin
                burst_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) :
                              $urandom_range(1, 8);
                gap_left <= $urandom_range(1, 5);
              end
            end
            ENT_CFG: begin
              if (idle) begin
                cfg_idx_i <= head.idx;
                cfg_wdata_i <= head.data;
                nxt_we = 1'b1;
                void'(item_backlog.pop_front());
              end
            end
            default: begin
              if (idle) void'(item_backlog.pop_front());
            end
          endcase
        end
      end
      start <= nxt_start;
      cfg_we_i <= nxt_we;
    end
  end

  // Monitor: every strobed record must match the oldest expectation.
  always @(posedge clk_i) begin : check_proc
    partition_record_t want;
    partition_record_t got;
    if (rst_ni && valid_o) begin
      got = {record_kind_o, partition_o, position_o, out_key_o, out_value_o, last_o};
      if (expected_records.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected record: %s", record_text(got));
      end else begin
        want = expected_records.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("record mismatch");
            $display("  expected %s", record_text(want));
            $display("  actual   %s", record_text(got));
          end
        end
      end
    end
  end

  task automatic push_item(input req_e req, input logic [KEY_W-1:0] key,
                           input logic [VALUE_W-1:0] val);
    backlog_entry_t e;
    e.kind = ENT_ITEM;
    e.req  = req;
    e.key  = key;
    e.val  = val;
    e.idx  = CFG_RADIX_BITS;
    e.data = '0;
    item_backlog.push_back(e);
  endtask

  task automatic push_cfg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] data);
    backlog_entry_t e;
    e.kind = ENT_CFG;
    e.req  = REQ_NONE;
    e.key  = '0;
    e.val  = '0;
    e.idx  = idx;
    e.data = data;
    item_backlog.push_back(e);
  endtask

  task automatic push_drain();
    backlog_entry_t e;
    e.kind = ENT_DRAIN;
    e.req  = REQ_NONE;
    e.key  = '0;
    e.val  = '0;
    e.idx  = CFG_RADIX_BITS;
    e.data = '0;
    item_backlog.push_back(e);
  endtask

  // Stimulus and end of run.
  initial begin : stim_proc
    int                    random_items;
    int                    n;
    logic [RADIX_W-1:0]    radix;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic [5:0]            hot;
    logic [KEY_W-1:0]      key;
    for (int i = 0; i < NUM_BUCKETS; i++) begin
      shadow_counts[i] = '0;
      shadow_ptrs[i] = '0;
    end
    shadow_radix = 3'd6;
    shadow_pad = '0;

    // Directed part. The first finalize runs at full fanout so that every
    // write pointer is loaded before any scatter.
    push_item(REQ_COUNT, '0, '1);
    push_item(REQ_COUNT, '1, '0);
    push_item(REQ_COUNT, 64'h3f, {$urandom, $urandom});
    push_item(REQ_COUNT, 64'h40, {$urandom, $urandom});
    push_item(REQ_NONE, {$urandom, $urandom}, {$urandom, $urandom});
    push_item(REQ_FINALIZE, '0, '0);
    push_item(REQ_SCATTER, '0, '1);
    push_item(REQ_SCATTER, '1, '0);
    push_item(REQ_SCATTER, 64'hffff_0000_ffff_003f, {$urandom, $urandom});
    push_item(REQ_SCATTER, '0, {$urandom, $urandom});
    push_drain();
    // Single partition with the widest padding.
    push_cfg(CFG_RADIX_BITS, 16'd0);
    push_cfg(CFG_PADDING_LENGTH, 16'hffff);
    push_item(REQ_COUNT, '1, '1);
    push_item(REQ_COUNT, {$urandom, $urandom}, '0);
    push_item(REQ_FINALIZE, '1, '1);
    push_item(REQ_SCATTER, '1, '1);
    // A radix above the maximum acts as the maximum.
    push_cfg(CFG_RADIX_BITS, 16'd7);
    push_cfg(CFG_PADDING_LENGTH, 16'd1);
    push_item(REQ_COUNT, 64'h7f, {$urandom, $urandom});
    push_item(REQ_COUNT, 64'h3f, {$urandom, $urandom});
    push_item(REQ_FINALIZE, {$urandom, $urandom}, {$urandom, $urandom});
    push_item(REQ_SCATTER, 64'hbf, {$urandom, $urandom});
    push_cfg(CFG_RADIX_BITS, 16'd1);
    push_cfg(CFG_PADDING_LENGTH, 16'h5555);
    push_item(REQ_COUNT, 64'h1, '0);
    push_item(REQ_FINALIZE, '0, '0);
    push_item(REQ_SCATTER, 64'h3, '1);
    push_item(REQ_SCATTER, 64'h2, '0);

    // Random phases: counts, a finalize, then scatters, with noise mixed in.
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 4))
          0:       radix = 3'd0;
          1:       radix = 3'd6;
          2:       radix = 3'd7;
          default: radix = 3'($urandom_range(0, 7));
        endcase
        cfg_data = 16'($urandom);
        cfg_data[RADIX_W-1:0] = radix;
        push_cfg(CFG_RADIX_BITS, cfg_data);
        case ($urandom_range(0, 3))
          0:       cfg_data = '0;
          1:       cfg_data = '1;
          default: cfg_data = 16'($urandom);
        endcase
        push_cfg(CFG_PADDING_LENGTH, cfg_data);
      end
      n = $urandom_range(0, 14);
      hot = 6'($urandom_range(0, 63));
      for (int k = 0; k < n; k++) begin
        key = {$urandom, $urandom};
        if ($urandom_range(0, 2) == 0) key[5:0] = hot;
        if ($urandom_range(0, 9) == 0) begin
          push_item(REQ_NONE, key, {$urandom, $urandom});
        end else begin
          push_item(REQ_COUNT, key, {$urandom, $urandom});
          random_items++;
        end
      end
      // Now and then the finalize is left out and scatters reuse old pointers.
      if ($urandom_range(0, 5) != 0) begin
        push_item(REQ_FINALIZE, {$urandom, $urandom}, {$urandom, $urandom});
        random_items++;
      end
      n = $urandom_range(1, 10);
      for (int k = 0; k < n; k++) begin
        key = {$urandom, $urandom};
        if ($urandom_range(0, 2) == 0) key[5:0] = hot;
        if ($urandom_range(0, 5) == 0) begin
          push_item(REQ_COUNT, key, {$urandom, $urandom});
        end else begin
          push_item(REQ_SCATTER, key, {$urandom, $urandom});
        end
        random_items++;
      end
      if ($urandom_range(0, 7) == 0) push_drain();
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait until all work is taken, all records are in and the block is quiet.
    while (!(item_backlog.size() == 0 && !start && !cfg_we_i &&
             expected_records.size() == 0 && quiet_cycles >= 2 * SETTLE_CYCLES)) begin
      @(posedge clk_i);
    end
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog for a hung run.
  initial begin
    #400000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

>>> filelist.f
rtl/rps_pkg.sv
rtl/rps_ram.sv
rtl/rps_count_store.sv
rtl/rps_offset_gen.sv
rtl/radix_partition_scatter_unit.sv
dv/tb_radix_partition_scatter_unit.sv
